FILE: rtl/core/skn_pkg.sv
// Shared types and constants for the SKINNY-128-384+ encryption core.
`default_nettype none
package skn_pkg;

    localparam int BLOCK_W   = 128;
    localparam int HALF_W    = 64;
    localparam int RC_W      = 6;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TK1_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TK1_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TK2_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TK2_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TK3_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TK3_HIGH = 3'd5;

    // Round state carried from cell to cell; byte i sits in bits 8i+7:8i
    typedef struct packed {
        logic [BLOCK_W-1:0] st;
        logic [BLOCK_W-1:0] k1;
        logic [BLOCK_W-1:0] k2;
        logic [BLOCK_W-1:0] k3;
        logic [RC_W-1:0]    rc;
    } t_round;

endpackage
`default_nettype wire

FILE: rtl/core/skn_in_if.sv
// Input channel: plaintext block and optional per-block TK2.
`default_nettype none
interface skn_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [63:0] tweak2_low;
    logic [63:0] tweak2_high;
    logic        use_tweak2;

    modport source (
        output valid, block_low, block_high, tweak2_low, tweak2_high, use_tweak2,
        input  ready
    );
    modport sink (
        input  valid, block_low, block_high, tweak2_low, tweak2_high, use_tweak2,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/skn_out_if.sv
// Output channel: ciphertext block.
`default_nettype none
interface skn_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_low;
    logic [63:0] cipher_high;

    modport source (
        output valid, cipher_low, cipher_high,
        input  ready
    );
    modport sink (
        input  valid, cipher_low, cipher_high,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/core/skn_round_cell.sv
// One SKINNY round plus tweakey update, registered, with its own valid/ready stage.
`default_nettype none
module skn_round_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  skn_pkg::t_round     i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output skn_pkg::t_round     o_data
);

    localparam logic [3:0] ROW_SRC [16] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd4, 4'd5, 4'd6,
        4'd10, 4'd11, 4'd8, 4'd9, 4'd13, 4'd14, 4'd15, 4'd12
    };
    localparam logic [3:0] TK_SRC [16] = '{
        4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11,
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
    };

    function automatic logic [7:0] nor_mix(input logic [7:0] x);
        logic [7:0] t;
        t = ~(((x >> 1) | x) >> 2) & 8'h11;
        return x ^ t;
    endfunction

    function automatic logic [7:0] bit_perm(input logic [7:0] x);
        return {x[2], x[1], x[7], x[6], x[4], x[0], x[3], x[5]};
    endfunction

    function automatic logic [7:0] sbox8(input logic [7:0] v);
        logic [7:0] x;
        x = nor_mix(v);
        x = bit_perm(x);
        x = nor_mix(x);
        x = bit_perm(x);
        x = nor_mix(x);
        x = bit_perm(x);
        x = nor_mix(x);
        return {x[7:3], x[1], x[2], x[0]};
    endfunction

    function automatic logic [7:0] lfsr2(input logic [7:0] v);
        return {v[6:0], v[7] ^ v[5]};
    endfunction

    function automatic logic [7:0] lfsr3(input logic [7:0] v);
        return {v[0] ^ v[6], v[7:1]};
    endfunction

    logic                               r_valid;
    skn_pkg::t_round                    r_data;
    skn_pkg::t_round                    n_data;
    logic [7:0]                         s [16];
    logic [7:0]                         sr [16];
    logic [skn_pkg::RC_W-1:0]           rc_nxt;

    always_comb begin
        rc_nxt = {i_data.rc[skn_pkg::RC_W-2:0], 1'b0}
               ^ {{(skn_pkg::RC_W-1){1'b0}}, i_data.rc[5] ^ i_data.rc[4] ^ 1'b1};

        for (int i = 0; i < 16; i++) begin
            s[i] = sbox8(i_data.st[8*i +: 8]);
        end
        s[0] = s[0] ^ {4'h0, rc_nxt[3:0]};
        s[4] = s[4] ^ {6'h00, rc_nxt[5:4]};
        s[8] = s[8] ^ 8'h02;
        for (int i = 0; i < 8; i++) begin
            s[i] = s[i] ^ i_data.k1[8*i +: 8] ^ i_data.k2[8*i +: 8] ^ i_data.k3[8*i +: 8];
        end

        for (int i = 0; i < 16; i++) begin
            sr[i] = s[ROW_SRC[i]];
        end

        n_data = i_data;
        n_data.rc = rc_nxt;
        for (int c = 0; c < 4; c++) begin
            n_data.st[8*c +: 8]        = sr[c] ^ sr[8+c] ^ sr[12+c];
            n_data.st[8*(4+c) +: 8]    = sr[c];
            n_data.st[8*(8+c) +: 8]    = sr[4+c] ^ sr[8+c];
            n_data.st[8*(12+c) +: 8]   = sr[c] ^ sr[8+c];
        end

        for (int i = 0; i < 16; i++) begin
            n_data.k1[8*i +: 8] = i_data.k1[8*TK_SRC[i] +: 8];
            n_data.k2[8*i +: 8] = i_data.k2[8*TK_SRC[i] +: 8];
            n_data.k3[8*i +: 8] = i_data.k3[8*TK_SRC[i] +: 8];
        end
        for (int i = 0; i < 8; i++) begin
            n_data.k2[8*i +: 8] = lfsr2(n_data.k2[8*i +: 8]);
            n_data.k3[8*i +: 8] = lfsr3(n_data.k3[8*i +: 8]);
        end
    end

    // Take a new beat whenever this stage is empty or its contents move on
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

FILE: rtl/core/skinny128_384_plus_encrypt.sv
// SKINNY-128-384+ encryption core: a row of round cells, one round per cell.
// Path: each input beat passes through ROUND_COUNT registered cells, one cell per round.
// Throughput: one block per cycle while the output is not stalled; every cell is a
// registered stage with its own valid bit, so a stalled output only fills the bubbles behind it.
// Reset: synchronous, active low; clears all stage valid bits and the tweakey
// registers to zero. Users must write tweakey registers only when idle; unchecked.
`default_nettype none
module skinny128_384_plus_encrypt #(
    parameter int ROUND_COUNT = 40
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    skn_in_if.sink                               i_in,
    skn_out_if.source                            o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [skn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [skn_pkg::HALF_W-1:0]      i_cfg_data
);

    logic [skn_pkg::HALF_W-1:0] r_tk1_low, r_tk1_high;
    logic [skn_pkg::HALF_W-1:0] r_tk2_low, r_tk2_high;
    logic [skn_pkg::HALF_W-1:0] r_tk3_low, r_tk3_high;

    logic            w_valid [ROUND_COUNT+1];
    logic            w_ready [ROUND_COUNT+1];
    skn_pkg::t_round w_data  [ROUND_COUNT+1];
    logic [ROUND_COUNT-1:0] w_stage_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tk1_low  <= '0;
            r_tk1_high <= '0;
            r_tk2_low  <= '0;
            r_tk2_high <= '0;
            r_tk3_low  <= '0;
            r_tk3_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                skn_pkg::CFG_TK1_LOW:  r_tk1_low  <= i_cfg_data;
                skn_pkg::CFG_TK1_HIGH: r_tk1_high <= i_cfg_data;
                skn_pkg::CFG_TK2_LOW:  r_tk2_low  <= i_cfg_data;
                skn_pkg::CFG_TK2_HIGH: r_tk2_high <= i_cfg_data;
                skn_pkg::CFG_TK3_LOW:  r_tk3_low  <= i_cfg_data;
                skn_pkg::CFG_TK3_HIGH: r_tk3_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Load the first cell straight from the input beat
    assign w_data[0] = '{
        st: {i_in.block_high, i_in.block_low},
        k1: {r_tk1_high, r_tk1_low},
        k2: (i_in.use_tweak2 ? {i_in.tweak2_high, i_in.tweak2_low}
                             : {r_tk2_high, r_tk2_low}),
        k3: {r_tk3_high, r_tk3_low},
        rc: '0
    };
    assign w_valid[0] = i_in.valid;
    assign i_in.ready = w_ready[0];

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_cell
        skn_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
        assign w_stage_full[g] = w_valid[g+1];
    end

    assign w_ready[ROUND_COUNT] = o_out.ready;
    assign o_out.valid          = w_valid[ROUND_COUNT];
    assign o_out.cipher_low     = w_data[ROUND_COUNT].st[skn_pkg::HALF_W-1:0];
    assign o_out.cipher_high    = w_data[ROUND_COUNT].st[skn_pkg::BLOCK_W-1:skn_pkg::HALF_W];

    a_accept_fills_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> w_valid[1] && w_data[1].rc == 6'h01)
        else $error("accepted beat did not reach the first round cell");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&w_stage_full) && !o_out.ready |-> !i_in.ready)
        else $error("input ready while every round cell is full and output stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    a_bubble_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_valid[1] |-> i_in.ready)
        else $error("input stalled although the first cell is empty");

endmodule
`default_nettype wire
